// ===== rtl/step_dir_pulse_generator_defines.svh =====
// Assertion macros used by the step/direction checker file
`ifndef STEP_DIR_PULSE_GENERATOR_DEFINES_SVH
`define STEP_DIR_PULSE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SDPG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SDPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sdpg_pkg.sv =====
// Package: constants, codes and control structs of the step/direction pulse generator
package sdpg_pkg;

   localparam int TICK_HZ = 1000000;

   localparam int MODE_W  = 3;
   localparam int AMT_W   = 32;
   localparam int STEPS_W = 31;
   localparam int SPEED_W = 19;
   localparam int RUN_W   = 2;
   localparam int HP_W    = 20;

   // restoring divider: one quotient bit per cycle over the bits of TICK_HZ
   localparam int DIV_W = $clog2(TICK_HZ + 1);
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam int DVS_W = AMT_W + 1;

   localparam int HP_MAX_INT = (1 << HP_W) - 1;
   localparam logic [HP_W-1:0] HP_MAX = HP_W'(HP_MAX_INT);
   localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

   localparam int POLL_RAW = TICK_HZ / 1000;
   localparam logic [HP_W-1:0] POLL_HP =
      HP_W'((POLL_RAW < 1) ? 1 : ((POLL_RAW > HP_MAX_INT) ? HP_MAX_INT : POLL_RAW));

   localparam int POS_RST_RAW = TICK_HZ / 200;
   localparam logic [HP_W-1:0] POS_HP_RST =
      HP_W'((POS_RST_RAW < 1) ? 1 :
            ((POS_RST_RAW > HP_MAX_INT) ? HP_MAX_INT : POS_RST_RAW));

   localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POS  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_VEL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ON   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_OFF  = 3'd4;

   localparam logic [RUN_W-1:0] RUN_OFF = 2'd0;
   localparam logic [RUN_W-1:0] RUN_POS = 2'd1;
   localparam logic [RUN_W-1:0] RUN_VEL = 2'd2;

   typedef struct packed {
      logic apply;       // apply the request transaction in this cycle
      logic vel_start;   // start velocity half-period division
      logic vel_finish;  // store velocity half period
      logic pos_start;   // start positioning half-period division
      logic pos_finish;  // store positioning half period
      logic load_rsp;    // capture response payload
   } sdpg_cmd_type;

   typedef struct packed {
      logic vel_div;     // pending request is a nonzero velocity move
      logic div_done;    // divider result available
   } sdpg_stat_type;

endpackage

// ===== rtl/sdpg_channels.sv =====
// Interfaces: request and response channels of the step/direction pulse generator
interface sdpg_req_if import sdpg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [AMT_W-1:0]  amount;

   modport source (output valid, mode, amount, input ready);
   modport sink   (input valid, mode, amount, output ready);
endinterface

interface sdpg_rsp_if import sdpg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               step_out;
   logic               dir_out;
   logic               enable_out;
   logic               sleep_out;
   logic [RUN_W-1:0]   active_mode;
   logic [STEPS_W-1:0] steps_left_out;

   modport source (output valid, step_out, dir_out, enable_out, sleep_out, active_mode,
                   steps_left_out, input ready);
   modport sink   (input valid, step_out, dir_out, enable_out, sleep_out, active_mode,
                   steps_left_out, output ready);
endinterface

// ===== rtl/sdpg_div.sv =====
// Restoring divider: TICK_HZ / divisor, clamped to a half period in ticks
module sdpg_div import sdpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [HP_W-1:0]  quotient
);

   logic             run_ff,  run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [DIV_W-1:0] q_ff,    q_in;
   logic [DVS_W-1:0] r_ff,    r_in;
   logic [DVS_W-1:0] d_ff,    d_in;
   logic [DVS_W-1:0] shifted;
   logic [DVS_W-1:0] q_ext;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      shifted = {r_ff[DVS_W-2:0], q_ff[DIV_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(DIV_W);
         q_in   = DIV_W'(TICK_HZ);
         r_in   = '0;
         d_in   = divisor;
      end else if (run_ff) begin
         if (shifted >= d_ff) begin
            r_in = shifted - d_ff;
            q_in = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   // half period is at least one tick and saturates at the counter range
   always_comb begin
      q_ext = DVS_W'(q_ff);
      if (q_ext == '0) begin
         quotient = HP_W'(1);
      end else if (q_ext > DVS_W'(HP_MAX)) begin
         quotient = HP_MAX;
      end else begin
         quotient = q_ext[HP_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/sdpg_datapath.sv =====
// Datapath: pin state, step counter, wait counter, half periods and response register
module sdpg_datapath import sdpg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic signed [AMT_W-1:0] req_amount,
   input  logic [SPEED_W-1:0]      csr_wdata,
   input  sdpg_cmd_type            cmd,
   output sdpg_stat_type           stat,
   output logic                    rsp_step_out,
   output logic                    rsp_dir_out,
   output logic                    rsp_enable_out,
   output logic                    rsp_sleep_out,
   output logic [RUN_W-1:0]        rsp_active_mode,
   output logic [STEPS_W-1:0]      rsp_steps_left_out
);

   logic [RUN_W-1:0]   run_mode_ff,  run_mode_in;
   logic [STEPS_W-1:0] steps_ff,     steps_in;
   logic [HP_W-1:0]    vel_hp_ff,    vel_hp_in;
   logic [HP_W-1:0]    pos_hp_ff,    pos_hp_in;
   logic [HP_W-1:0]    wait_ff,      wait_in;
   logic               rising_ff,    rising_in;
   logic               step_ff,      step_in;
   logic               dir_ff,       dir_in;
   logic               enable_ff,    enable_in;
   logic               sleep_ff,     sleep_in;

   logic               rsp_step_ff, rsp_dir_ff, rsp_enable_ff, rsp_sleep_ff;
   logic [RUN_W-1:0]   rsp_mode_ff;
   logic [STEPS_W-1:0] rsp_steps_ff;

   logic [AMT_W-1:0]   raw;
   logic               neg;
   logic [AMT_W-1:0]   mag_full;
   logic [STEPS_W-1:0] mag;
   logic [STEPS_W-1:0] svc_steps;
   logic [HP_W-1:0]    svc_wait;
   logic [SPEED_W-1:0] speed;
   logic [DVS_W-1:0]   divisor;
   logic               div_done;
   logic [HP_W-1:0]    div_q;

   // magnitude of the amount, most negative value saturates
   always_comb begin
      raw      = req_amount;
      neg      = raw[AMT_W-1];
      mag_full = neg ? (~raw + 1'b1) : raw;
      mag      = mag_full[AMT_W-1] ? STEPS_MAX : mag_full[STEPS_W-1:0];
   end

   assign stat.vel_div  = (req_mode == MODE_VEL) && (mag != '0);
   assign stat.div_done = div_done;

   always_comb begin
      speed   = (csr_wdata == '0) ? SPEED_W'(1) : csr_wdata;
      divisor = cmd.pos_start ? DVS_W'({speed, 1'b0}) : DVS_W'({mag, 1'b0});
   end

   sdpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.vel_start | cmd.pos_start),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      run_mode_in = run_mode_ff;
      steps_in    = steps_ff;
      vel_hp_in   = vel_hp_ff;
      pos_hp_in   = pos_hp_ff;
      wait_in     = wait_ff;
      rising_in   = rising_ff;
      step_in     = step_ff;
      dir_in      = dir_ff;
      enable_in   = enable_ff;
      sleep_in    = sleep_ff;
      svc_steps   = steps_ff;
      svc_wait    = POLL_HP;

      if (cmd.apply) begin
         case (req_mode)
            MODE_TICK: begin
               if (wait_ff > HP_W'(1)) begin
                  wait_in = wait_ff - 1'b1;
               end else begin
                  case (run_mode_ff)
                     RUN_POS: begin
                        step_in = rising_ff;
                        // count a step on its falling edge
                        if (!rising_ff && steps_ff != '0) begin
                           svc_steps = steps_ff - 1'b1;
                        end
                        steps_in  = svc_steps;
                        rising_in = ~rising_ff;
                        if (svc_steps == '0) begin
                           run_mode_in = RUN_OFF;
                        end
                        svc_wait = pos_hp_ff;
                     end
                     RUN_VEL: begin
                        step_in   = rising_ff;
                        rising_in = ~rising_ff;
                        svc_wait  = vel_hp_ff;
                     end
                     default: begin
                        svc_wait = POLL_HP;
                     end
                  endcase
                  wait_in = (svc_wait == '0) ? HP_W'(1) : svc_wait;
               end
            end
            MODE_POS: begin
               dir_in      = ~neg;
               steps_in    = mag;
               run_mode_in = (mag != '0) ? RUN_POS : RUN_OFF;
            end
            MODE_VEL: begin
               // zero speed only; nonzero speed goes through the divider
               dir_in      = ~neg;
               steps_in    = '0;
               vel_hp_in   = '0;
               run_mode_in = RUN_OFF;
            end
            MODE_ON: begin
               sleep_in  = 1'b0;
               enable_in = 1'b1;
            end
            MODE_OFF: begin
               sleep_in    = 1'b1;
               enable_in   = 1'b0;
               run_mode_in = RUN_OFF;
               steps_in    = '0;
               vel_hp_in   = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.vel_start) begin
         dir_in      = ~neg;
         steps_in    = '0;
         run_mode_in = RUN_VEL;
      end
      if (cmd.vel_finish) begin
         vel_hp_in = div_q;
      end
      if (cmd.pos_finish) begin
         pos_hp_in = div_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff <= RUN_OFF;
         steps_ff    <= '0;
         vel_hp_ff   <= '0;
         pos_hp_ff   <= POS_HP_RST;
         wait_ff     <= HP_W'(1);
         rising_ff   <= 1'b1;
         step_ff     <= 1'b0;
         dir_ff      <= 1'b1;
         enable_ff   <= 1'b0;
         sleep_ff    <= 1'b1;
      end else begin
         run_mode_ff <= run_mode_in;
         steps_ff    <= steps_in;
         vel_hp_ff   <= vel_hp_in;
         pos_hp_ff   <= pos_hp_in;
         wait_ff     <= wait_in;
         rising_ff   <= rising_in;
         step_ff     <= step_in;
         dir_ff      <= dir_in;
         enable_ff   <= enable_in;
         sleep_ff    <= sleep_in;
      end
   end

   // response register holds the state after the transaction
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_step_ff   <= step_in;
         rsp_dir_ff    <= dir_in;
         rsp_enable_ff <= enable_in;
         rsp_sleep_ff  <= sleep_in;
         rsp_mode_ff   <= run_mode_in;
         rsp_steps_ff  <= steps_in;
      end
   end

   assign rsp_step_out       = rsp_step_ff;
   assign rsp_dir_out        = rsp_dir_ff;
   assign rsp_enable_out     = rsp_enable_ff;
   assign rsp_sleep_out      = rsp_sleep_ff;
   assign rsp_active_mode    = rsp_mode_ff;
   assign rsp_steps_left_out = rsp_steps_ff;

endmodule

// ===== rtl/sdpg_ctrl.sv =====
// Controller: handshakes, divider sequencing and response valid
module sdpg_ctrl import sdpg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic          csr_we,
   input  sdpg_stat_type stat,
   output sdpg_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_VEL_DIV = 3'b010,
      ST_POS_DIV = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           accept;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_IDLE) && !csr_we && out_free;
      accept    = req_valid && req_ready;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               cmd.pos_start = 1'b1;
               state_in      = ST_POS_DIV;
            end else if (accept) begin
               if (stat.vel_div) begin
                  cmd.vel_start = 1'b1;
                  state_in      = ST_VEL_DIV;
               end else begin
                  cmd.apply    = 1'b1;
                  cmd.load_rsp = 1'b1;
               end
            end
         end
         ST_VEL_DIV: begin
            if (stat.div_done) begin
               cmd.vel_finish = 1'b1;
               cmd.load_rsp   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_POS_DIV: begin
            if (stat.div_done) begin
               cmd.pos_finish = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/step_dir_pulse_generator.sv =====
// Top level: step/direction pulse generator for a stepper driver
//
//   channel   direction  handshake       payload
//   req_chan  in         valid/ready     mode, amount
//   rsp_chan  out        valid/ready     step_out, dir_out, enable_out, sleep_out,
//                                        active_mode, steps_left_out
//   csr       in         csr_we          csr_wdata = step rate for position moves
//
// Ticks, position moves, zero-speed velocity moves and power commands answer in the cycle
// after acceptance. A nonzero velocity move and a csr write run the restoring divider,
// one quotient bit per cycle over the DIV_W bits of TICK_HZ. A velocity move answers once
// the divider is done, a csr write gives no response, and the next transaction is accepted
// only after the controller has returned to idle. A new transaction enters only while
// the response register is empty or being read, and never in a cycle with csr_we high.
// Reset is synchronous; the pin state resets to step 0, dir 1, enable 0, sleep 1 (response register is not reset).
module step_dir_pulse_generator import sdpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   sdpg_req_if.sink           req_chan,
   sdpg_rsp_if.source         rsp_chan,
   input  logic               csr_we,
   input  logic [SPEED_W-1:0] csr_wdata
);

   sdpg_cmd_type  cmd;
   sdpg_stat_type stat;

   sdpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .csr_we    (csr_we),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdpg_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_chan.mode),
      .req_amount         (req_chan.amount),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_step_out       (rsp_chan.step_out),
      .rsp_dir_out        (rsp_chan.dir_out),
      .rsp_enable_out     (rsp_chan.enable_out),
      .rsp_sleep_out      (rsp_chan.sleep_out),
      .rsp_active_mode    (rsp_chan.active_mode),
      .rsp_steps_left_out (rsp_chan.steps_left_out)
   );

endmodule

// ===== rtl/sdpg_checker.sv =====
// Checker on the top-level ports of the step/direction pulse generator, with its bind
`include "step_dir_pulse_generator_defines.svh"

module sdpg_checker import sdpg_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [MODE_W-1:0]  req_mode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               step_out,
   input logic               enable_out,
   input logic               sleep_out,
   input logic [RUN_W-1:0]   active_mode,
   input logic [STEPS_W-1:0] steps_left_out
);

   // a tick transaction answers in the next cycle
   `SDPG_ASSERT_NEXT(a_tick_latency, clock, reset, req_valid && req_ready && req_mode == MODE_TICK, rsp_valid, "tick response late")

   // enable and sleep pins are opposite whenever a response is valid
   `SDPG_ASSERT_NOW(a_pins_opposite, clock, reset, rsp_valid, enable_out != sleep_out, "enable and sleep agree")

   // remaining steps only exist during a position move
   `SDPG_ASSERT_NOW(a_steps_mode, clock, reset, rsp_valid && steps_left_out != '0, active_mode == RUN_POS, "steps left outside positioning")

   `SDPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(step_out) && $stable(steps_left_out) && $stable(active_mode), "stalled response changed")

endmodule

bind step_dir_pulse_generator sdpg_checker u_sdpg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_mode       (req_chan.mode),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .step_out       (rsp_chan.step_out),
   .enable_out     (rsp_chan.enable_out),
   .sleep_out      (rsp_chan.sleep_out),
   .active_mode    (rsp_chan.active_mode),
   .steps_left_out (rsp_chan.steps_left_out)
);
